### design/rz_pkg.sv
// ----------------------------------------------------------------------------
// rz_pkg: triangle rasterizer shared definitions
// Frame size, field widths, beat payloads and module interconnect structs.
// ----------------------------------------------------------------------------
package rz_pkg;

    localparam int FRAME_WIDTH  = 64;
    localparam int FRAME_HEIGHT = 64;
    localparam int NPIX         = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int PIX_AW       = $clog2(NPIX);
    localparam int X_W          = $clog2(FRAME_WIDTH);
    localparam int Y_W          = $clog2(FRAME_HEIGHT);

    localparam int CW      = 12;   // screen coordinate
    localparam int ZW      = 16;   // depth
    localparam int COLOR_W = 24;
    localparam int CNT_W   = 13;
    localparam int D_W     = 14;   // coordinate difference
    localparam int MA_W    = 16;   // multiplier operand a
    localparam int W_W     = 29;   // edge weights, multiplier operand b
    localparam int PROD_W  = MA_W + W_W;
    localparam int NUM_W   = PROD_W + 2;
    localparam int Q_W     = 16;   // quotient magnitude

    localparam logic signed [ZW-1:0] DEPTH_MIN = {1'b1, {(ZW-1){1'b0}}};
    localparam logic                 CMD_DRAW  = 1'b0;
    localparam logic                 CMD_READ  = 1'b1;

    typedef struct packed {
        logic                   command;
        logic signed [CW-1:0]   ax;
        logic signed [CW-1:0]   ay;
        logic signed [ZW-1:0]   az;
        logic signed [CW-1:0]   bx;
        logic signed [CW-1:0]   by_row;
        logic signed [ZW-1:0]   bz;
        logic signed [CW-1:0]   cx;
        logic signed [CW-1:0]   cy;
        logic signed [ZW-1:0]   cz;
        logic [COLOR_W-1:0]     fill_color;
    } cmd_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0]     pixel_color;
        logic signed [ZW-1:0]   pixel_depth;
        logic [CNT_W-1:0]       pixels_written;
    } res_item_t;

    typedef struct packed {
        logic                   wr_en;
        logic [PIX_AW-1:0]      wr_addr;
        logic [COLOR_W-1:0]     wr_color;
        logic signed [ZW-1:0]   wr_depth;
        logic [PIX_AW-1:0]      rd_addr;
    } store_req_t;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic signed [W_W-1:0]   den;
    } div_req_t;

    function automatic logic [PIX_AW-1:0] pix_index(input logic [X_W-1:0] x,
                                                    input logic [Y_W-1:0] y);
        pix_index = PIX_AW'(x) + PIX_AW'(y) * PIX_AW'(FRAME_WIDTH);
    endfunction

endpackage

### design/rz_cmd_if.sv
// ----------------------------------------------------------------------------
// rz_cmd_if: command channel
// Valid/ready channel carrying one draw or read command per beat.
// ----------------------------------------------------------------------------
interface rz_cmd_if;
    import rz_pkg::*;

    logic      valid;
    logic      ready;
    cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/rz_res_if.sv
// ----------------------------------------------------------------------------
// rz_res_if: result channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface rz_res_if;
    import rz_pkg::*;

    logic      valid;
    logic      ready;
    res_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/rz_pixel_store.sv
// ----------------------------------------------------------------------------
// rz_pixel_store: color and depth frame memories
// One write and one registered read per cycle; clearing sweep after reset.
// ----------------------------------------------------------------------------
module rz_pixel_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rz_pkg::store_req_t           req,
    output logic [rz_pkg::COLOR_W-1:0]   rd_color,
    output logic signed [rz_pkg::ZW-1:0] rd_depth,
    output logic                         busy
);
    import rz_pkg::*;

    logic [COLOR_W-1:0]   color_mem [NPIX];
    logic signed [ZW-1:0] depth_mem [NPIX];
    logic [PIX_AW:0]      clr_cnt_reg;
    logic [PIX_AW:0]      clr_cnt_next;

    assign busy = (clr_cnt_reg != (PIX_AW + 1)'(NPIX));

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (busy)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            color_mem[clr_cnt_reg[PIX_AW-1:0]] <= '0;
            depth_mem[clr_cnt_reg[PIX_AW-1:0]] <= DEPTH_MIN;
        end
        else if (req.wr_en)
        begin
            color_mem[req.wr_addr] <= req.wr_color;
            depth_mem[req.wr_addr] <= req.wr_depth;
        end
        rd_color <= color_mem[req.rd_addr];
        rd_depth <= depth_mem[req.rd_addr];
    end

endmodule

### design/rz_divider.sv
// ----------------------------------------------------------------------------
// rz_divider: iterative signed divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module rz_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rz_pkg::div_req_t              req,
    output logic                          done,
    output logic signed [rz_pkg::Q_W-1:0] quo
);
    import rz_pkg::*;

    localparam int SC_W = $clog2(Q_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SC_W-1:0]  cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dsh_reg, dsh_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [NUM_W-1:0] num_abs;
    logic [W_W-1:0]   den_abs;
    logic             ge;
    logic signed [Q_W:0] q_signed;

    assign num_abs  = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
    assign den_abs  = req.den[W_W-1] ? W_W'(-req.den) : W_W'(req.den);
    assign ge       = (rem_reg >= dsh_reg);
    assign q_signed = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    assign quo      = q_signed[Q_W-1:0];
    assign done     = done_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = SC_W'(Q_W - 1);
            neg_next  = req.num[NUM_W-1] ^ req.den[W_W-1];
            rem_next  = num_abs;
            dsh_next  = NUM_W'(den_abs) << (Q_W - 1);
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[Q_W-2:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

endmodule

### design/triangle_rasterizer_zbuffer.sv
// ----------------------------------------------------------------------------
// triangle_rasterizer_zbuffer: flat triangle rasterizer with depth buffer
// Read: RD1 and RD2 states, then FIN. Draw: setup and check, then each box pixel is
//   tested; pixels inside pass multiply, divide and depth steps (shared multiplier, 16-step divider).
// Commands: one at a time; ready again once the result is queued.
// Reset: the frame stores are swept clear over all FRAME_WIDTH*FRAME_HEIGHT
//   pixels; commands are held off until the sweep ends.
// ----------------------------------------------------------------------------
module triangle_rasterizer_zbuffer (
    input logic     clk,
    input logic     rst_n,
    rz_cmd_if.sink  cmd,
    rz_res_if.source res
);
    import rz_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SETUP = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_TEST  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_DEPTH = 4'd6;
    localparam logic [3:0] S_RD1   = 4'd7;
    localparam logic [3:0] S_RD2   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    localparam logic signed [CW:0] XMAX = (CW + 1)'(FRAME_WIDTH - 1);
    localparam logic signed [CW:0] YMAX = (CW + 1)'(FRAME_HEIGHT - 1);

    logic [3:0]               state_reg, state_next;
    logic [2:0]               step_reg, step_next;
    cmd_item_t                item_reg, item_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [W_W-1:0]    uz_reg, uz_next;
    logic signed [W_W-1:0]    ux_reg, ux_next;
    logic signed [W_W-1:0]    uy_reg, uy_next;
    logic signed [W_W-1:0]    uxc_reg, uxc_next;
    logic signed [W_W-1:0]    uyc_reg, uyc_next;
    logic signed [W_W-1:0]    w0_reg, w0_next;
    logic signed [NUM_W-1:0]  num_reg, num_next;
    logic signed [ZW-1:0]     z_reg, z_next;
    logic [X_W-1:0]           px_reg, px_next;
    logic [Y_W-1:0]           py_reg, py_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [COLOR_W-1:0]       rcol_reg, rcol_next;
    logic signed [ZW-1:0]     rdep_reg, rdep_next;
    logic                     out_valid_reg, out_valid_next;
    res_item_t                out_data_reg, out_data_next;

    logic signed [CW-1:0]     xmin, xmax, ymin, ymax;
    logic signed [CW:0]       x0c, x1c, y0c, y1c;
    logic                     box_empty;
    logic signed [D_W-1:0]    dxb, dyb, dxc, dyc, ex, ey0, eya;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [W_W-1:0]    mul_b;
    logic signed [W_W-1:0]    p_w;
    logic signed [W_W-1:0]    w0c;
    logic                     in_tri;
    logic                     last_row, last_col, adv_done;
    logic [X_W-1:0]           adv_px;
    logic [Y_W-1:0]           adv_py;
    logic signed [W_W-1:0]    adv_ux, adv_uy, adv_uxc, adv_uyc;
    logic                     rd_in_frame;
    store_req_t               sreq;
    logic [COLOR_W-1:0]       rd_color;
    logic signed [ZW-1:0]     rd_depth;
    logic                     store_busy;
    div_req_t                 dreq;
    logic                     div_done;
    logic signed [Q_W-1:0]    div_quo;

    rz_pixel_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (sreq),
        .rd_color (rd_color),
        .rd_depth (rd_depth),
        .busy     (store_busy)
    );

    rz_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .done  (div_done),
        .quo   (div_quo)
    );

    // bounding box and edge deltas
    always_comb
    begin
        xmin = (item_reg.ax < item_reg.bx) ? item_reg.ax : item_reg.bx;
        xmin = (xmin < item_reg.cx) ? xmin : item_reg.cx;
        xmax = (item_reg.ax > item_reg.bx) ? item_reg.ax : item_reg.bx;
        xmax = (xmax > item_reg.cx) ? xmax : item_reg.cx;
        ymin = (item_reg.ay < item_reg.by_row) ? item_reg.ay : item_reg.by_row;
        ymin = (ymin < item_reg.cy) ? ymin : item_reg.cy;
        ymax = (item_reg.ay > item_reg.by_row) ? item_reg.ay : item_reg.by_row;
        ymax = (ymax > item_reg.cy) ? ymax : item_reg.cy;
        x0c  = xmin[CW-1] ? '0 : (CW + 1)'(xmin);
        y0c  = ymin[CW-1] ? '0 : (CW + 1)'(ymin);
        x1c  = ((CW + 1)'(xmax) > XMAX) ? XMAX : (CW + 1)'(xmax);
        y1c  = ((CW + 1)'(ymax) > YMAX) ? YMAX : (CW + 1)'(ymax);
        box_empty = (x0c > x1c) || (y0c > y1c);
        dxb  = D_W'(item_reg.bx) - D_W'(item_reg.ax);
        dyb  = D_W'(item_reg.by_row) - D_W'(item_reg.ay);
        dxc  = D_W'(item_reg.cx) - D_W'(item_reg.ax);
        dyc  = D_W'(item_reg.cy) - D_W'(item_reg.ay);
        ex   = D_W'(x0c) - D_W'(item_reg.ax);
        ey0  = D_W'(y0c) - D_W'(item_reg.ay);
        eya  = D_W'(item_reg.ay) - D_W'(y0c);
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SETUP:
            begin
                case (step_reg)
                    3'd0:    begin mul_a = MA_W'(dxc); mul_b = W_W'(dyb); end
                    3'd1:    begin mul_a = MA_W'(dxb); mul_b = W_W'(dyc); end
                    3'd2:    begin mul_a = MA_W'(dxb); mul_b = W_W'(eya); end
                    3'd3:    begin mul_a = MA_W'(ex);  mul_b = W_W'(dyb); end
                    3'd4:    begin mul_a = MA_W'(dxc); mul_b = W_W'(ey0); end
                    3'd5:    begin mul_a = MA_W'(ex);  mul_b = W_W'(dyc); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_MUL:
            begin
                case (step_reg)
                    3'd0:    begin mul_a = item_reg.az; mul_b = w0_reg; end
                    3'd1:    begin mul_a = item_reg.bz; mul_b = uy_reg; end
                    3'd2:    begin mul_a = item_reg.cz; mul_b = ux_reg; end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign p_w       = prod_reg[W_W-1:0];

    // inside test and raster step
    always_comb
    begin
        w0c = uz_reg - ux_reg - uy_reg;
        if (!uz_reg[W_W-1])
        begin
            in_tri = !w0c[W_W-1] && !ux_reg[W_W-1] && !uy_reg[W_W-1];
        end
        else
        begin
            in_tri = (w0c[W_W-1] || w0c == '0) && (ux_reg[W_W-1] || ux_reg == '0)
                     && (uy_reg[W_W-1] || uy_reg == '0);
        end
        last_row = (py_reg == y1c[Y_W-1:0]);
        last_col = (px_reg == x1c[X_W-1:0]);
        adv_done = last_row && last_col;
        if (last_row)
        begin
            adv_px  = px_reg + 1'b1;
            adv_py  = y0c[Y_W-1:0];
            adv_uxc = uxc_reg + W_W'(dyb);
            adv_uyc = uyc_reg - W_W'(dyc);
            adv_ux  = adv_uxc;
            adv_uy  = adv_uyc;
        end
        else
        begin
            adv_px  = px_reg;
            adv_py  = py_reg + 1'b1;
            adv_uxc = uxc_reg;
            adv_uyc = uyc_reg;
            adv_ux  = ux_reg - W_W'(dxb);
            adv_uy  = uy_reg + W_W'(dxc);
        end
    end

    assign rd_in_frame = !item_reg.ax[CW-1] && ((CW + 1)'(item_reg.ax) <= XMAX)
                         && !item_reg.ay[CW-1] && ((CW + 1)'(item_reg.ay) <= YMAX);

    always_comb
    begin
        sreq.wr_en    = (state_reg == S_DEPTH) && (rd_depth < z_reg);
        sreq.wr_addr  = pix_index(px_reg, py_reg);
        sreq.wr_color = item_reg.fill_color;
        sreq.wr_depth = z_reg;
        if (state_reg == S_RD1 || state_reg == S_RD2)
        begin
            sreq.rd_addr = pix_index(item_reg.ax[X_W-1:0], item_reg.ay[Y_W-1:0]);
        end
        else
        begin
            sreq.rd_addr = pix_index(px_reg, py_reg);
        end
        dreq.start = (state_reg == S_MUL) && (step_reg == 3'd4);
        dreq.num   = num_reg;
        dreq.den   = uz_reg;
    end

    assign cmd.ready = (state_reg == S_IDLE) && !store_busy;
    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        item_next      = item_reg;
        uz_next        = uz_reg;
        ux_next        = ux_reg;
        uy_next        = uy_reg;
        uxc_next       = uxc_reg;
        uyc_next       = uyc_reg;
        w0_next        = w0_reg;
        num_next       = num_reg;
        z_next         = z_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        cnt_next       = cnt_reg;
        rcol_next      = rcol_reg;
        rdep_next      = rdep_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_data_next  = out_data_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid && cmd.ready)
                begin
                    item_next  = cmd.data;
                    cnt_next   = '0;
                    step_next  = '0;
                    state_next = (cmd.data.command == CMD_READ) ? S_RD1 : S_SETUP;
                end
            end
            S_SETUP:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    3'd1:    uz_next  = p_w;
                    3'd2:    uz_next  = uz_reg - p_w;
                    3'd3:    uxc_next = p_w;
                    3'd4:    uxc_next = uxc_reg + p_w;
                    3'd5:    uyc_next = p_w;
                    3'd6:
                    begin
                        uyc_next   = uyc_reg - p_w;
                        state_next = S_CHECK;
                    end
                    default: ;
                endcase
            end
            S_CHECK:
            begin
                if (uz_reg == '0 || box_empty)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    px_next    = x0c[X_W-1:0];
                    py_next    = y0c[Y_W-1:0];
                    ux_next    = uxc_reg;
                    uy_next    = uyc_reg;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (in_tri)
                begin
                    w0_next    = w0c;
                    step_next  = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    px_next    = adv_px;
                    py_next    = adv_py;
                    ux_next    = adv_ux;
                    uy_next    = adv_uy;
                    uxc_next   = adv_uxc;
                    uyc_next   = adv_uyc;
                    state_next = adv_done ? S_FIN : S_TEST;
                end
            end
            S_MUL:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    3'd1:    num_next = NUM_W'(prod_reg);
                    3'd2:    num_next = num_reg + NUM_W'(prod_reg);
                    3'd3:    num_next = num_reg + NUM_W'(prod_reg);
                    3'd4:    state_next = S_DIV;
                    default: ;
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    z_next     = div_quo;
                    state_next = S_DEPTH;
                end
            end
            S_DEPTH:
            begin
                if (rd_depth < z_reg && cnt_reg != '1)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                px_next    = adv_px;
                py_next    = adv_py;
                ux_next    = adv_ux;
                uy_next    = adv_uy;
                uxc_next   = adv_uxc;
                uyc_next   = adv_uyc;
                state_next = adv_done ? S_FIN : S_TEST;
            end
            S_RD1:
            begin
                state_next = S_RD2;
            end
            S_RD2:
            begin
                rcol_next  = rd_in_frame ? rd_color : '0;
                rdep_next  = rd_in_frame ? rd_depth : DEPTH_MIN;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    if (item_reg.command == CMD_READ)
                    begin
                        out_data_next.pixel_color    = rcol_reg;
                        out_data_next.pixel_depth    = rdep_reg;
                        out_data_next.pixels_written = '0;
                    end
                    else
                    begin
                        out_data_next.pixel_color    = '0;
                        out_data_next.pixel_depth    = '0;
                        out_data_next.pixels_written = cnt_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        prod_reg     <= prod_next;
        uz_reg       <= uz_next;
        ux_reg       <= ux_next;
        uy_reg       <= uy_next;
        uxc_reg      <= uxc_next;
        uyc_reg      <= uyc_next;
        w0_reg       <= w0_next;
        num_reg      <= num_next;
        z_reg        <= z_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        cnt_reg      <= cnt_next;
        rcol_reg     <= rcol_next;
        rdep_reg     <= rdep_next;
        out_data_reg <= out_data_next;
    end

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide step");

    a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        sreq.wr_en |-> !store_busy)
        else $error("pixel write during clearing sweep");

    a_draw_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && item_reg.command == CMD_DRAW && res.ready)
        |=> res.valid && res.data.pixel_color == '0 && res.data.pixel_depth == '0)
        else $error("draw result carries pixel data");

endmodule
